// ===== hw/rtl/wdff_pkg.sv =====
// types, codes and header offsets for the wep data frame filter
package wdff_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DS_W     = 2;
  localparam int unsigned NID_W    = 48;
  localparam int unsigned KIDX_W   = 2;
  localparam int unsigned PAIR_W   = NID_W + KIDX_W;

  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam logic [BYTE_W-1:0] FC_DATA      = 8'h08;
  localparam logic [BYTE_W-1:0] FC_QOS_DATA  = 8'h88;
  localparam logic [BYTE_W-1:0] FC_NULL_DATA = 8'h48;
  localparam logic [BYTE_W-1:0] FC_QOS_NULL  = 8'hC8;

  localparam logic [DS_W-1:0] DS_NONE = 2'd0;
  localparam logic [DS_W-1:0] DS_TO   = 2'd2;
  localparam logic [DS_W-1:0] DS_BOTH = 2'd3;

  localparam logic [POS_W-1:0] BSSID_AT_NONE  = 6'd16;
  localparam logic [POS_W-1:0] BSSID_AT_TO    = 6'd4;
  localparam logic [POS_W-1:0] BSSID_AT_OTHER = 6'd10;
  localparam logic [POS_W-1:0] BSSID_LEN      = 6'd6;
  localparam logic [POS_W-1:0] KEY_AT_3ADDR   = 6'd27;
  localparam logic [POS_W-1:0] KEY_AT_4ADDR   = 6'd33;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_DATA    = 3'd0,
    ST_UNPROTECTED = 3'd1,
    ST_PAD_NONZERO = 3'd2,
    ST_SEEN        = 3'd3,
    ST_CAPTURED    = 3'd4,
    ST_TABLE_FULL  = 3'd5,
    ST_TOO_SHORT   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_PARSE  = 3'b001,
    S_SEARCH = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  function automatic logic [POS_W-1:0] bssid_start(input logic [DS_W-1:0] ds);
    logic [POS_W-1:0] s;
    if (ds == DS_NONE) begin
      s = BSSID_AT_NONE;
    end else if (ds == DS_TO) begin
      s = BSSID_AT_TO;
    end else begin
      s = BSSID_AT_OTHER;
    end
    return s;
  endfunction

  function automatic logic [POS_W-1:0] key_pos(input logic [DS_W-1:0] ds);
    return (ds == DS_BOTH) ? KEY_AT_4ADDR : KEY_AT_3ADDR;
  endfunction

  function automatic logic is_data(input logic [BYTE_W-1:0] c);
    return (c == FC_DATA) || (c == FC_QOS_DATA) || (c == FC_NULL_DATA) || (c == FC_QOS_NULL);
  endfunction

endpackage

// ===== hw/rtl/wep_data_frame_filter_core.sv =====
// header parser for protected 802.11 data frames with a table of seen bssid/key pairs
// bytes are taken one per cycle unless in_stall is up; a verdict that needs no table lookup
// is registered in the cycle after the final byte. a lookup walks the pair memory one
// entry per cycle through its single read port, and the input is stalled until its
// verdict is committed. reset empties the table by clearing its fill count; no clearing
// pass over the memory is needed.
module wep_data_frame_filter_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wdff_pkg::BYTE_W-1:0]         in_frame_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wdff_pkg::STATUS_W-1:0]       out_status,
  output logic [wdff_pkg::DS_W-1:0]           out_ds_mode,
  output logic [wdff_pkg::NID_W-1:0]          out_network_id,
  output logic [wdff_pkg::KIDX_W-1:0]         out_key_index
);
  import wdff_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // per-frame parse state
  logic [POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic [BYTE_W-1:0]  frame_class_r, frame_class_nxt;
  logic [2:0]         layout_r, layout_nxt;
  logic [NID_W-1:0]   net_r, net_nxt;
  logic [BYTE_W-1:0]  key_r, key_nxt;

  // lookup control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               cmp_valid_r, cmp_valid_nxt;
  logic               found_r, found_nxt;
  logic [PAIR_W-1:0]  pair_r, pair_nxt;
  logic [DS_W-1:0]    ds_hold_r, ds_hold_nxt;

  // output word
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DS_W-1:0]    out_ds_r, out_ds_nxt;
  logic [NID_W-1:0]   out_nid_r, out_nid_nxt;
  logic [KIDX_W-1:0]  out_kidx_r, out_kidx_nxt;

  // pair memory
  logic [PAIR_W-1:0]  pair_mem [TABLE_DEPTH];
  logic [PAIR_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               mem_we;

  // byte update and verdict
  logic               in_acc;
  logic               out_free;
  logic [POS_W-1:0]   pos_inc;
  logic [BYTE_W-1:0]  class_upd;
  logic [2:0]         layout_upd;
  logic [NID_W-1:0]   net_upd;
  logic [BYTE_W-1:0]  key_upd;
  logic [DS_W-1:0]    ds_cur;
  logic [POS_W-1:0]   bs;
  logic [POS_W-1:0]   kp;
  logic [STATUS_W-1:0] v_status;
  logic [DS_W-1:0]    v_ds;
  logic [NID_W-1:0]   v_nid;
  logic [KIDX_W-1:0]  v_kidx;
  logic               v_search;
  logic               match;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_PARSE) || (in_last_byte && out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    pos_inc    = (byte_pos_r < POS_MAX) ? byte_pos_r + 6'd1 : byte_pos_r;
    class_upd  = frame_class_r;
    layout_upd = layout_r;
    net_upd    = net_r;
    key_upd    = key_r;
    ds_cur     = layout_r[1:0];
    bs         = bssid_start(ds_cur);
    kp         = key_pos(ds_cur);
    if (byte_pos_r == 6'd0) begin
      class_upd = in_frame_byte;
    end else if (byte_pos_r == 6'd1) begin
      // tods is bit 0, fromds bit 1 of the flags byte
      ds_cur     = {in_frame_byte[0], in_frame_byte[1]};
      layout_upd = {in_frame_byte[6], ds_cur};
      kp         = key_pos(ds_cur);
    end else begin
      if ((byte_pos_r >= bs) && (byte_pos_r < bs + BSSID_LEN)) begin
        net_upd = {net_r[NID_W-BYTE_W-1:0], in_frame_byte};
      end
      if (byte_pos_r == kp) begin
        key_upd = in_frame_byte;
      end
    end

    v_status = ST_NOT_DATA;
    v_ds     = '0;
    v_nid    = '0;
    v_kidx   = '0;
    v_search = 1'b0;
    if (!is_data(class_upd)) begin
      v_status = ST_NOT_DATA;
    end else if (pos_inc < 6'd2) begin
      v_status = ST_TOO_SHORT;
    end else begin
      v_ds = ds_cur;
      if (!layout_upd[2]) begin
        v_status = ST_UNPROTECTED;
      end else if (pos_inc <= kp) begin
        v_status = ST_TOO_SHORT;
      end else begin
        v_nid  = net_upd;
        v_kidx = key_upd[7:6];
        if (key_upd[5:0] != 6'd0) begin
          v_status = ST_PAD_NONZERO;
        end else begin
          v_search = 1'b1;
        end
      end
    end
  end

  assign match   = cmp_valid_r && (rd_data_r == pair_r);
  assign rd_addr = iss_r[IDX_W-1:0];
  assign wr_addr = used_r[IDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    byte_pos_nxt    = byte_pos_r;
    frame_class_nxt = frame_class_r;
    layout_nxt      = layout_r;
    net_nxt         = net_r;
    key_nxt         = key_r;
    used_nxt        = used_r;
    iss_nxt         = iss_r;
    cmp_valid_nxt   = 1'b0;
    found_nxt       = found_r;
    pair_nxt        = pair_r;
    ds_hold_nxt     = ds_hold_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_ds_nxt      = out_ds_r;
    out_nid_nxt     = out_nid_r;
    out_kidx_nxt    = out_kidx_r;
    mem_we          = 1'b0;

    case (state_r)
      S_PARSE: begin
        if (in_acc) begin
          if (in_last_byte) begin
            byte_pos_nxt    = '0;
            frame_class_nxt = '0;
            layout_nxt      = '0;
            net_nxt         = '0;
            key_nxt         = '0;
            if (v_search) begin
              pair_nxt    = {v_nid, v_kidx};
              ds_hold_nxt = v_ds;
              iss_nxt     = '0;
              found_nxt   = 1'b0;
              state_nxt   = S_SEARCH;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = v_status;
              out_ds_nxt     = v_ds;
              out_nid_nxt    = v_nid;
              out_kidx_nxt   = v_kidx;
            end
          end else begin
            byte_pos_nxt    = pos_inc;
            frame_class_nxt = class_upd;
            layout_nxt      = layout_upd;
            net_nxt         = net_upd;
            key_nxt         = key_upd;
          end
        end
      end
      S_SEARCH: begin
        if (match) begin
          found_nxt = 1'b1;
          state_nxt = S_COMMIT;
        end else if (iss_r < used_r) begin
          iss_nxt       = iss_r + 1'b1;
          cmp_valid_nxt = 1'b1;
        end else if (!cmp_valid_r) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ds_nxt    = ds_hold_r;
          out_nid_nxt   = pair_r[PAIR_W-1:KIDX_W];
          out_kidx_nxt  = pair_r[KIDX_W-1:0];
          if (found_r) begin
            out_status_nxt = ST_SEEN;
          end else if (used_r >= DEPTH_C) begin
            out_status_nxt = ST_TABLE_FULL;
          end else begin
            out_status_nxt = ST_CAPTURED;
            mem_we         = 1'b1;
            used_nxt       = used_r + 1'b1;
          end
          state_nxt = S_PARSE;
        end
      end
      default: begin
        state_nxt = S_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[wr_addr] <= pair_r;
    end
    rd_data_r <= pair_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_PARSE;
      byte_pos_r    <= '0;
      frame_class_r <= '0;
      layout_r      <= '0;
      net_r         <= '0;
      key_r         <= '0;
      used_r        <= '0;
      iss_r         <= '0;
      cmp_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_pos_r    <= byte_pos_nxt;
      frame_class_r <= frame_class_nxt;
      layout_r      <= layout_nxt;
      net_r         <= net_nxt;
      key_r         <= key_nxt;
      used_r        <= used_nxt;
      iss_r         <= iss_nxt;
      cmp_valid_r   <= cmp_valid_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r       <= pair_nxt;
    ds_hold_r    <= ds_hold_nxt;
    out_status_r <= out_status_nxt;
    out_ds_r     <= out_ds_nxt;
    out_nid_r    <= out_nid_nxt;
    out_kidx_r   <= out_kidx_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_ds_mode    = out_ds_r;
  assign out_network_id = out_nid_r;
  assign out_key_index  = out_kidx_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C)
    else $error("pair count beyond table depth");

  a_used_grows_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> (out_valid_r && (out_status_r == ST_CAPTURED)))
    else $error("pair count changed without a captured verdict");

  a_compare_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (state_r == S_SEARCH))
    else $error("memory compare outside search");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (iss_r <= used_r))
    else $error("lookup read beyond filled entries");

endmodule

// ===== verif/testbench.sv =====
// testbench for the wep data frame filter core: directed and random frames vs a predictor
module testbench;
  import wdff_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned RANDOM_WORDS   = 1550;
  localparam int unsigned MAX_FRAME      = 80;
  localparam int unsigned DRAIN_CYCLES   = TABLE_DEPTH + 16;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [DS_W-1:0]   DS_FROM      = 2'd1;
  localparam logic [BYTE_W-1:0] FL_PROTECTED = 8'h40;
  localparam logic [BYTE_W-1:0] FL_FREE_BITS = 8'hBC;
  localparam logic [5:0]        KEY_PAD_MASK = 6'h3f;

  typedef struct packed {
    status_t             status;
    logic [DS_W-1:0]     ds_mode;
    logic [NID_W-1:0]    network_id;
    logic [KIDX_W-1:0]   key_index;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_frame_byte = '0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DS_W-1:0]     out_ds_mode;
  logic [NID_W-1:0]    out_network_id;
  logic [KIDX_W-1:0]   out_key_index;

  wep_data_frame_filter_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_byte  (in_frame_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_ds_mode    (out_ds_mode),
    .out_network_id (out_network_id),
    .out_key_index  (out_key_index)
  );

  always #4 clk = ~clk;

  // predictor state: one frame in progress plus the table of pairs seen so far
  logic [POS_W-1:0]   hdr_pos = '0;
  logic [BYTE_W-1:0]  hdr_class = '0;
  logic [2:0]         hdr_layout = '0;
  logic [NID_W-1:0]   hdr_bssid = '0;
  logic [BYTE_W-1:0]  hdr_key = '0;
  logic [PAIR_W-1:0]  known_pairs[$];
  verdict_t           pending_verdicts[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int status_count[8];

  function automatic int bssid_offset(input logic [DS_W-1:0] ds);
    case (ds)
      DS_NONE: return int'(BSSID_AT_NONE);
      DS_TO:   return int'(BSSID_AT_TO);
      default: return int'(BSSID_AT_OTHER);
    endcase
  endfunction

  function automatic int key_offset(input logic [DS_W-1:0] ds);
    return (ds == DS_BOTH) ? int'(KEY_AT_4ADDR) : int'(KEY_AT_3ADDR);
  endfunction

  // byte 1 carries tods in bit 0 and fromds in bit 1
  function automatic logic [BYTE_W-1:0] ds_flags(input logic [DS_W-1:0] ds);
    return {6'b0, ds[0], ds[1]};
  endfunction

  function automatic logic [NID_W-1:0] rand_bssid();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return r[NID_W-1:0];
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_data_class();
    case ($urandom_range(3))
      0:       return FC_DATA;
      1:       return FC_QOS_DATA;
      2:       return FC_NULL_DATA;
      default: return FC_QOS_NULL;
    endcase
  endfunction

  task automatic track_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  n;
    logic [DS_W-1:0]   ds;
    logic [PAIR_W-1:0] pair;
    verdict_t          v;
    bit                found;
    int                nid_at;
    pos = hdr_pos;
    ds = hdr_layout[1:0];
    found = 0;
    if (pos == 0) begin
      hdr_class = b;
    end else if (pos == 1) begin
      ds = {b[0], b[1]};
      hdr_layout = {b[6], ds};
    end else begin
      nid_at = bssid_offset(ds);
      if (pos >= nid_at && pos < nid_at + BSSID_LEN) begin
        hdr_bssid = {hdr_bssid[NID_W-9:0], b};
      end
      if (pos == key_offset(ds)) begin
        hdr_key = b;
      end
    end
    if (pos < POS_MAX) begin
      hdr_pos = pos + 1'b1;
    end
    if (last) begin
      n = hdr_pos;
      v = '{status: ST_NOT_DATA, ds_mode: '0, network_id: '0, key_index: '0};
      if (!(hdr_class inside {FC_DATA, FC_QOS_DATA, FC_NULL_DATA, FC_QOS_NULL})) begin
        v.status = ST_NOT_DATA;
      end else if (n < 2) begin
        v.status = ST_TOO_SHORT;
      end else begin
        v.ds_mode = ds;
        if (!hdr_layout[2]) begin
          v.status = ST_UNPROTECTED;
        end else if (n <= key_offset(ds)) begin
          v.status = ST_TOO_SHORT;
        end else begin
          v.network_id = hdr_bssid;
          v.key_index = hdr_key[7:6];
          if ((hdr_key[5:0] & KEY_PAD_MASK) != 0) begin
            v.status = ST_PAD_NONZERO;
          end else begin
            pair = {hdr_bssid, hdr_key[7:6]};
            foreach (known_pairs[i]) begin
              if (known_pairs[i] == pair) found = 1;
            end
            if (found) begin
              v.status = ST_SEEN;
            end else if (known_pairs.size() >= TABLE_DEPTH) begin
              v.status = ST_TABLE_FULL;
            end else begin
              known_pairs.push_back(pair);
              v.status = ST_CAPTURED;
            end
          end
        end
      end
      pending_verdicts.push_back(v);
      hdr_pos = '0;
      hdr_class = '0;
      hdr_layout = '0;
      hdr_bssid = '0;
      hdr_key = '0;
    end
  endtask

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame_byte(b, last);
    words_sent++;
  endtask

  // lays out a frame with the bssid and key byte where the ds bits of fl place them
  task automatic send_frame(input logic [BYTE_W-1:0] fc, input logic [BYTE_W-1:0] fl,
                            input logic [NID_W-1:0] bssid, input logic [BYTE_W-1:0] key,
                            input int len);
    logic [BYTE_W-1:0] frame_buf[MAX_FRAME];
    logic [DS_W-1:0]   ds;
    int                nid_at;
    ds = {fl[0], fl[1]};
    nid_at = bssid_offset(ds);
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(255));
    frame_buf[0] = fc;
    frame_buf[1] = fl;
    for (int k = 0; k < 6; k++) frame_buf[nid_at + k] = bssid[NID_W-1-8*k -: 8];
    frame_buf[key_offset(ds)] = key;
    for (int i = 0; i < len; i++) send_word(frame_buf[i], i == len - 1);
    frames_sent++;
  endtask

  // well-formed protected frame; reuse picks a pair already in the table
  task automatic send_good_frame(input bit reuse, input int extra);
    logic [DS_W-1:0]   ds;
    logic [BYTE_W-1:0] fl;
    logic [NID_W-1:0]  bssid;
    logic [KIDX_W-1:0] kidx;
    logic [PAIR_W-1:0] pair;
    ds = DS_W'($urandom_range(3));
    fl = ds_flags(ds) | FL_PROTECTED | (8'($urandom_range(255)) & FL_FREE_BITS);
    bssid = rand_bssid();
    kidx = KIDX_W'($urandom_range(3));
    if (reuse && known_pairs.size() > 0) begin
      pair = known_pairs[$urandom_range(known_pairs.size() - 1)];
      bssid = pair[PAIR_W-1:KIDX_W];
      kidx = pair[KIDX_W-1:0];
    end
    send_frame(rand_data_class(), fl, bssid, {kidx, 6'b0}, key_offset(ds) + 1 + extra);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      status_count[out_status]++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected word: status %0d ds %0d nid %012h kidx %0d",
                   out_status, out_ds_mode, out_network_id, out_key_index);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status || out_ds_mode !== want.ds_mode ||
            out_network_id !== want.network_id || out_key_index !== want.key_index) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected status %0d ds %0d nid %012h kidx %0d",
                     want.status, want.ds_mode, want.network_id, want.key_index);
            $display("          actual   status %0d ds %0d nid %012h kidx %0d",
                     out_status, out_ds_mode, out_network_id, out_key_index);
          end
        end
      end
    end
  end

  // counts cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_not_data();
    send_frame(8'h00, FL_PROTECTED, rand_bssid(), 8'h00, 30);
    send_frame(8'hff, 8'hff, '1, 8'hff, 1);
    send_frame(8'h09, FL_PROTECTED | ds_flags(DS_BOTH), '1, 8'h00, 40);
    send_frame(8'h80, 8'h00, '0, 8'h00, 2);
  endtask

  task automatic test_too_short();
    send_frame(FC_DATA, 8'h00, '0, 8'h00, 1);
    send_frame(FC_QOS_DATA, FL_PROTECTED, '1, 8'h00, KEY_AT_3ADDR);
    send_frame(FC_QOS_NULL, FL_PROTECTED | ds_flags(DS_BOTH), '1, 8'h00, KEY_AT_4ADDR);
    send_frame(FC_NULL_DATA, FL_PROTECTED | ds_flags(DS_TO), rand_bssid(), 8'h00, 2);
  endtask

  task automatic test_unprotected();
    send_frame(FC_DATA, ds_flags(DS_FROM), rand_bssid(), 8'h00, 30);
    send_frame(FC_QOS_DATA, 8'hbf, '1, 8'h00, 2);
  endtask

  task automatic test_pad_nonzero();
    send_frame(FC_DATA, FL_PROTECTED, rand_bssid(), 8'h01, 28);
    send_frame(FC_QOS_NULL, FL_PROTECTED | ds_flags(DS_BOTH), '1, 8'hff, 34);
    send_frame(FC_NULL_DATA, FL_PROTECTED | ds_flags(DS_TO), '0, 8'h20, 29);
  endtask

  // every data class, every address layout and every key index once
  task automatic test_layouts();
    logic [BYTE_W-1:0] classes[4];
    classes = '{FC_DATA, FC_QOS_DATA, FC_NULL_DATA, FC_QOS_NULL};
    for (int d = 0; d < 4; d++) begin
      send_frame(classes[d], FL_PROTECTED | ds_flags(DS_W'(d)),
                 (d == 0) ? '0 : (d == 1) ? '1 : rand_bssid(), {2'(d), 6'b0},
                 key_offset(DS_W'(d)) + 1);
    end
  endtask

  task automatic test_repeat_pair();
    send_frame(FC_DATA, FL_PROTECTED, '1, 8'h40, 28);
    send_frame(FC_QOS_DATA, FL_PROTECTED | ds_flags(DS_BOTH) | 8'h80, '1, 8'h40, 34);
    send_frame(FC_DATA, FL_PROTECTED, '1, 8'h80, 28);
  endtask

  // position counter saturates well past every offset
  task automatic test_long_frame();
    send_frame(FC_QOS_DATA, FL_PROTECTED | ds_flags(DS_TO), rand_bssid(), 8'hc0, MAX_FRAME);
    send_frame(FC_NULL_DATA, FL_PROTECTED | ds_flags(DS_BOTH), rand_bssid(), 8'h00, 64);
  endtask

  task automatic test_random_traffic();
    int idle_plan[4];
    int stall_plan[4];
    int target;
    int roll;
    logic [DS_W-1:0] ds;
    idle_plan = '{0, 57, 0, 29};
    stall_plan = '{0, 0, 57, 29};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) begin
        roll = $urandom_range(99);
        ds = DS_W'($urandom_range(3));
        if (roll < 65) begin
          send_good_frame($urandom_range(99) < 30,
                          ($urandom_range(19) == 0) ? $urandom_range(MAX_FRAME - 34)
                                                    : $urandom_range(6));
        end else if (roll < 75) begin
          // truncated before the key byte
          send_frame(rand_data_class(), ds_flags(ds) | FL_PROTECTED, rand_bssid(), 8'h00,
                     $urandom_range(key_offset(ds), 1));
        end else if (roll < 82) begin
          send_frame(rand_data_class(), ds_flags(ds) | FL_PROTECTED, rand_bssid(),
                     8'($urandom_range(255)), key_offset(ds) + 1 + $urandom_range(4));
        end else begin
          send_frame(($urandom_range(1) == 0) ? rand_data_class() : 8'($urandom_range(255)),
                     8'($urandom_range(255)), rand_bssid(), 8'($urandom_range(255)),
                     $urandom_range(40, 1));
        end
      end
    end
  endtask

  task automatic test_table_full();
    send_idle_pct = 29;
    recv_stall_pct = 29;
    while (known_pairs.size() < TABLE_DEPTH) send_good_frame(0, 0);
    send_good_frame(0, 0);
    send_good_frame(0, 3);
    send_good_frame(1, 0);
    send_frame(FC_DATA, FL_PROTECTED, rand_bssid(), 8'h3f, 28);
    send_good_frame(0, 1);
    send_good_frame(1, 2);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_not_data();
    test_too_short();
    test_unprotected();
    test_pad_nonzero();
    test_layouts();
    test_repeat_pair();
    test_long_frame();
    test_random_traffic();
    test_table_full();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_verdicts.size();
    $display("covered %0d frames in %0d words, %0d verdicts, %0d table pairs",
             frames_sent, words_sent, verdicts_seen, known_pairs.size());
    $display("by status: nodata %0d unprot %0d pad %0d seen %0d capt %0d full %0d short %0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4], status_count[5], status_count[6]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
